FILE: hw/rtl/bipc_pkg.sv
// ----------------------------------------------------------------------------
// bipc_pkg
// types and constants shared by the backlight and idle power controller
// ----------------------------------------------------------------------------
package bipc_pkg;

    localparam int TIMER_BITS    = 16;
    localparam int LEVEL_BITS    = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_BRIGHT_SCREEN = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BRIGHT_KEY    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIM_SCREEN    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIM_KEY       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_IDLE   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_KEY_IDLE      = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_POWER_DELAY   = 3'd6;

    // register reset values; power delay is 300 hundredths of a second
    localparam logic [LEVEL_BITS-1:0] BRIGHT_SCREEN_RST = 8'd8;
    localparam logic [LEVEL_BITS-1:0] BRIGHT_KEY_RST    = 8'd4;
    localparam logic [LEVEL_BITS-1:0] DIM_SCREEN_RST    = 8'd4;
    localparam logic [LEVEL_BITS-1:0] DIM_KEY_RST       = 8'd1;
    localparam logic [TIMER_BITS-1:0] SCREEN_IDLE_RST   = 16'd60;
    localparam logic [TIMER_BITS-1:0] KEY_IDLE_RST      = 16'd5;
    localparam logic [TIMER_BITS-1:0] POWER_DELAY_RST   = TIMER_BITS'(300 / 100);

    typedef struct packed {
        logic lid_up;
        logic on_ac;
        logic key_event;
        logic msg_request;
        logic power_down_request;
        logic suspend_request;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] screen_level;
        logic [LEVEL_BITS-1:0] key_level;
        logic                  screen_blanked;
        logic                  key_light_on;
        logic                  backlight_power_on;
        logic                  led_on;
        logic                  power_off_pulse;
    } out_item_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] bright_screen_level;
        logic [LEVEL_BITS-1:0] bright_key_level;
        logic [LEVEL_BITS-1:0] dim_screen_level;
        logic [LEVEL_BITS-1:0] dim_key_level;
        logic [TIMER_BITS-1:0] screen_idle_seconds;
        logic [TIMER_BITS-1:0] key_idle_seconds;
        logic [TIMER_BITS-1:0] power_down_delay;
    } cfg_regs_t;

    // lid and supply are tracked as a known bit plus the last sampled value
    typedef struct packed {
        logic                  lid_known;
        logic                  lid_val;
        logic                  sup_known;
        logic                  sup_val;
        logic                  key_latch;
        logic                  msg_active;
        logic                  flash_phase;
        logic [LEVEL_BITS-1:0] saved_key_level;
        logic [LEVEL_BITS-1:0] screen_drive;
        logic [LEVEL_BITS-1:0] key_drive;
        logic                  blank_flag;
        logic                  key_power_flag;
        logic                  backlight_flag;
        logic                  led_flag;
        logic [TIMER_BITS-1:0] key_cd;
        logic [TIMER_BITS-1:0] screen_cd;
        logic [TIMER_BITS-1:0] power_cd;
    } ctl_state_t;

endpackage

FILE: hw/rtl/bipc_in_if.sv
// ----------------------------------------------------------------------------
// bipc_in_if
// tick sample channel: valid, ready and one sampled input item
// ----------------------------------------------------------------------------
interface bipc_in_if import bipc_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/bipc_out_if.sv
// ----------------------------------------------------------------------------
// bipc_out_if
// result channel: valid, ready and one result item
// ----------------------------------------------------------------------------
interface bipc_out_if import bipc_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/bipc_cfg_if.sv
// ----------------------------------------------------------------------------
// bipc_cfg_if
// register write channel: valid, ready, register index and write data
// ----------------------------------------------------------------------------
interface bipc_cfg_if import bipc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/bipc_step.sv
// ----------------------------------------------------------------------------
// bipc_step
// next-state and result logic for one tick: countdowns, key and message
// rules, power-down request, supply and lid changes
// ----------------------------------------------------------------------------
module bipc_step import bipc_pkg::*; (
    input  ctl_state_t cur,
    input  cfg_regs_t  regs,
    input  in_item_t   item,
    output ctl_state_t nxt,
    output out_item_t  res
);

    logic       pulse;
    logic       on_battery;
    ctl_state_t t;

    always_comb
    begin
        t     = cur;
        pulse = 1'b0;

        // running countdowns advance first
        if (cur.key_cd != '0)
        begin
            t.key_cd = cur.key_cd - TIMER_BITS'(1);
            if (t.key_cd == '0)
            begin
                t.key_power_flag = 1'b0;
            end
        end
        if (cur.screen_cd != '0)
        begin
            t.screen_cd = cur.screen_cd - TIMER_BITS'(1);
            if (t.screen_cd == '0)
            begin
                t.blank_flag = 1'b1;
            end
        end
        if (cur.power_cd != '0)
        begin
            t.power_cd = cur.power_cd - TIMER_BITS'(1);
            if (t.power_cd == '0)
            begin
                pulse = 1'b1;
            end
        end

        if (item.key_event)
        begin
            t.key_latch = 1'b1;
        end
        if (item.msg_request)
        begin
            t.msg_active  = 1'b1;
            t.flash_phase = 1'b1;
        end

        on_battery = cur.sup_known && !cur.sup_val;

        if ((on_battery || t.msg_active) && t.key_latch)
        begin
            if (on_battery)
            begin
                t.key_cd         = regs.key_idle_seconds;
                t.screen_cd      = regs.screen_idle_seconds;
                t.key_latch      = 1'b0;
                t.blank_flag     = 1'b0;
                t.key_power_flag = 1'b1;
            end
            // a saved level of zero means nothing saved, flashing goes on
            if (t.msg_active && t.saved_key_level != '0)
            begin
                t.key_drive       = t.saved_key_level;
                t.led_flag        = 1'b0;
                t.saved_key_level = '0;
                t.msg_active      = 1'b0;
            end
        end

        if (t.msg_active)
        begin
            if (t.saved_key_level == '0)
            begin
                t.saved_key_level = t.key_drive;
            end
            t.led_flag = t.flash_phase;
            if (t.flash_phase)
            begin
                t.key_drive   = t.saved_key_level;
                t.flash_phase = 1'b0;
            end
            else
            begin
                t.key_drive   = '0;
                t.flash_phase = 1'b1;
            end
        end

        // suspend wins over power-down
        if (item.suspend_request)
        begin
            t.power_cd = '0;
        end
        else if (item.power_down_request)
        begin
            t.power_cd = regs.power_down_delay;
        end

        if (!cur.sup_known || cur.sup_val != item.on_ac)
        begin
            t.sup_known = 1'b1;
            t.sup_val   = item.on_ac;
            if (item.on_ac)
            begin
                t.blank_flag     = 1'b0;
                t.key_cd         = '0;
                t.screen_cd      = '0;
                t.key_power_flag = 1'b1;
                t.screen_drive   = regs.bright_screen_level;
                t.key_drive      = regs.bright_key_level;
            end
            else
            begin
                t.key_cd       = regs.key_idle_seconds;
                t.screen_cd    = regs.screen_idle_seconds;
                t.screen_drive = regs.dim_screen_level;
                t.key_drive    = regs.dim_key_level;
            end
        end

        if (!cur.lid_known || cur.lid_val != item.lid_up)
        begin
            t.lid_known      = 1'b1;
            t.lid_val        = item.lid_up;
            t.backlight_flag = item.lid_up;
        end
    end

    assign nxt = t;

    assign res.screen_level       = t.screen_drive;
    assign res.key_level          = t.key_drive;
    assign res.screen_blanked     = t.blank_flag;
    assign res.key_light_on       = t.key_power_flag;
    assign res.backlight_power_on = t.backlight_flag;
    assign res.led_on             = t.led_flag;
    assign res.power_off_pulse    = pulse;

endmodule

FILE: hw/rtl/backlight_idle_power_controller.sv
// ----------------------------------------------------------------------------
// backlight_idle_power_controller
// once-per-tick backlight, keyboard light, message flash and power-off timer
// control
// ----------------------------------------------------------------------------
//   channel   dir   contents
//   in_ch     sink  one tick sample: lid, supply, key, message, power requests
//   out_ch    src   levels, blank, key light, backlight power, led, off pulse
//   cfg       sink  register index and write data, always ready
//
// one tick sample per clock while out_ch keeps up; the result is registered on accept
// a new sample is taken while a result waits, as long as out_ch takes it
// in the same cycle (ready = output register empty or being drained)
// reset puts registers at their defaults and timers at key 5, screen 60
// no clearing pass: the block is ready right after reset
// ----------------------------------------------------------------------------
module backlight_idle_power_controller import bipc_pkg::*; (
    input logic           clk,
    input logic           rst_n,
    bipc_in_if.sink       in_ch,
    bipc_out_if.source    out_ch,
    bipc_cfg_if.sink      cfg
);

    cfg_regs_t  regs_reg;
    ctl_state_t state_reg;
    ctl_state_t state_next;
    out_item_t  out_data_reg;
    out_item_t  out_data_next;
    logic       out_valid_reg;
    logic       in_fire;
    logic       cfg_fire;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign cfg.ready   = 1'b1;
    assign cfg_fire    = cfg.valid;

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    bipc_step u_step (
        .cur  (state_reg),
        .regs (regs_reg),
        .item (in_ch.data),
        .nxt  (state_next),
        .res  (out_data_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.bright_screen_level <= BRIGHT_SCREEN_RST;
            regs_reg.bright_key_level    <= BRIGHT_KEY_RST;
            regs_reg.dim_screen_level    <= DIM_SCREEN_RST;
            regs_reg.dim_key_level       <= DIM_KEY_RST;
            regs_reg.screen_idle_seconds <= SCREEN_IDLE_RST;
            regs_reg.key_idle_seconds    <= KEY_IDLE_RST;
            regs_reg.power_down_delay    <= POWER_DELAY_RST;
        end
        else if (cfg_fire)
        begin
            unique case (cfg.index)
                REG_BRIGHT_SCREEN: regs_reg.bright_screen_level <= cfg.data[LEVEL_BITS-1:0];
                REG_BRIGHT_KEY:    regs_reg.bright_key_level    <= cfg.data[LEVEL_BITS-1:0];
                REG_DIM_SCREEN:    regs_reg.dim_screen_level    <= cfg.data[LEVEL_BITS-1:0];
                REG_DIM_KEY:       regs_reg.dim_key_level       <= cfg.data[LEVEL_BITS-1:0];
                REG_SCREEN_IDLE:   regs_reg.screen_idle_seconds <= cfg.data[TIMER_BITS-1:0];
                REG_KEY_IDLE:      regs_reg.key_idle_seconds    <= cfg.data[TIMER_BITS-1:0];
                REG_POWER_DELAY:   regs_reg.power_down_delay    <= cfg.data[TIMER_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.lid_known       <= 1'b0;
            state_reg.lid_val         <= 1'b0;
            state_reg.sup_known       <= 1'b0;
            state_reg.sup_val         <= 1'b0;
            state_reg.key_latch       <= 1'b0;
            state_reg.msg_active      <= 1'b0;
            state_reg.flash_phase     <= 1'b0;
            state_reg.saved_key_level <= '0;
            state_reg.screen_drive    <= '0;
            state_reg.key_drive       <= '0;
            state_reg.blank_flag      <= 1'b0;
            state_reg.key_power_flag  <= 1'b1;
            state_reg.backlight_flag  <= 1'b0;
            state_reg.led_flag        <= 1'b0;
            state_reg.key_cd          <= KEY_IDLE_RST;
            state_reg.screen_cd       <= SCREEN_IDLE_RST;
            state_reg.power_cd        <= '0;
            out_valid_reg             <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted sample did not produce a result");

    a_pulse_from_timer: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (!out_data_reg.power_off_pulse || $past(state_reg.power_cd) == 16'd1))
        else $error("power-off pulse without expiring timer");

    a_ac_no_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.sup_known && state_reg.sup_val) |->
        (!state_reg.blank_flag && state_reg.screen_cd == '0 && state_reg.key_cd == '0))
        else $error("idle timers armed or screen blanked on ac");

    a_backlight_follows_lid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.lid_known |-> (out_data_reg.backlight_power_on == state_reg.lid_val))
        else $error("backlight power does not follow lid");
`endif

endmodule

FILE: bench/bipc_tick_checker.sv
// ----------------------------------------------------------------------------
// bipc_tick_checker
// watches the tick, result and register channels of the backlight controller,
// predicts every result from its own copy of the state and registers, and
// compares each delivered result with the oldest prediction
// ----------------------------------------------------------------------------
module bipc_tick_checker import bipc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  in_item_t                 in_data,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  out_item_t                out_data,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output int                       fail_count,
    output int                       pending,
    output int                       checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 10;

    // last seen lid or supply sample, unknown until the first tick
    typedef enum logic [1:0]
    {
        SEEN_LOW     = 2'd0,
        SEEN_HIGH    = 2'd1,
        SEEN_UNKNOWN = 2'd2
    } seen_t;

    cfg_regs_t             regs;
    seen_t                 lid_seen;
    seen_t                 supply_seen;
    logic                  key_latch;
    logic                  msg_active;
    logic                  flash_phase;
    logic [LEVEL_BITS-1:0] saved_key;
    logic [LEVEL_BITS-1:0] screen_drive;
    logic [LEVEL_BITS-1:0] key_drive;
    logic                  blank;
    logic                  key_power;
    logic                  backlight;
    logic                  led;
    logic [TIMER_BITS-1:0] key_cd;
    logic [TIMER_BITS-1:0] screen_cd;
    logic [TIMER_BITS-1:0] power_cd;

    out_item_t             predicted_outputs[$];
    out_item_t             want;
    logic                  bad;

    function automatic out_item_t predict_tick(input in_item_t s);
        out_item_t r;
        logic      pulse;
        pulse = 1'b0;

        // countdowns advance before the rules
        if (key_cd != '0)
        begin
            key_cd = key_cd - TIMER_BITS'(1);
            if (key_cd == '0)
                key_power = 1'b0;
        end
        if (screen_cd != '0)
        begin
            screen_cd = screen_cd - TIMER_BITS'(1);
            if (screen_cd == '0)
                blank = 1'b1;
        end
        if (power_cd != '0)
        begin
            power_cd = power_cd - TIMER_BITS'(1);
            if (power_cd == '0)
                pulse = 1'b1;
        end

        if (s.key_event)
            key_latch = 1'b1;
        if (s.msg_request)
        begin
            msg_active  = 1'b1;
            flash_phase = 1'b1;
        end

        if ((supply_seen == SEEN_LOW || msg_active) && key_latch)
        begin
            // key press on battery re-arms the idle countdowns
            if (supply_seen == SEEN_LOW)
            begin
                key_cd    = regs.key_idle_seconds;
                screen_cd = regs.screen_idle_seconds;
                key_latch = 1'b0;
                blank     = 1'b0;
                key_power = 1'b1;
            end
            // a zero saved level cannot end the flashing
            if (msg_active && saved_key != '0)
            begin
                key_drive  = saved_key;
                led        = 1'b0;
                saved_key  = '0;
                msg_active = 1'b0;
            end
        end

        if (msg_active)
        begin
            if (saved_key == '0)
                saved_key = key_drive;
            led = flash_phase;
            if (flash_phase)
            begin
                key_drive   = saved_key;
                flash_phase = 1'b0;
            end
            else
            begin
                key_drive   = '0;
                flash_phase = 1'b1;
            end
        end

        if (s.power_down_request && !s.suspend_request)
            power_cd = regs.power_down_delay;
        if (s.suspend_request)
            power_cd = '0;

        if (supply_seen != seen_t'({1'b0, s.on_ac}))
        begin
            supply_seen = seen_t'({1'b0, s.on_ac});
            if (s.on_ac)
            begin
                blank        = 1'b0;
                key_cd       = '0;
                screen_cd    = '0;
                key_power    = 1'b1;
                screen_drive = regs.bright_screen_level;
                key_drive    = regs.bright_key_level;
            end
            else
            begin
                key_cd       = regs.key_idle_seconds;
                screen_cd    = regs.screen_idle_seconds;
                screen_drive = regs.dim_screen_level;
                key_drive    = regs.dim_key_level;
            end
        end

        if (lid_seen != seen_t'({1'b0, s.lid_up}))
        begin
            lid_seen  = seen_t'({1'b0, s.lid_up});
            backlight = s.lid_up;
        end

        r.screen_level       = screen_drive;
        r.key_level          = key_drive;
        r.screen_blanked     = blank;
        r.key_light_on       = key_power;
        r.backlight_power_on = backlight;
        r.led_on             = led;
        r.power_off_pulse    = pulse;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.bright_screen_level = BRIGHT_SCREEN_RST;
            regs.bright_key_level    = BRIGHT_KEY_RST;
            regs.dim_screen_level    = DIM_SCREEN_RST;
            regs.dim_key_level       = DIM_KEY_RST;
            regs.screen_idle_seconds = SCREEN_IDLE_RST;
            regs.key_idle_seconds    = KEY_IDLE_RST;
            regs.power_down_delay    = POWER_DELAY_RST;
            lid_seen     = SEEN_UNKNOWN;
            supply_seen  = SEEN_UNKNOWN;
            key_latch    = 1'b0;
            msg_active   = 1'b0;
            flash_phase  = 1'b0;
            saved_key    = '0;
            screen_drive = '0;
            key_drive    = '0;
            blank        = 1'b0;
            key_power    = 1'b1;
            backlight    = 1'b0;
            led          = 1'b0;
            key_cd       = KEY_IDLE_RST;
            screen_cd    = SCREEN_IDLE_RST;
            power_cd     = '0;
            predicted_outputs.delete();
            fail_count = 0;
            pending    = 0;
            checked    = 0;
        end
        else
        begin
            // a result leaves before the item taken at the same edge is predicted
            if (out_valid && out_ready)
            begin
                if (predicted_outputs.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: result with no transaction pending: scr %0d key %0d",
                                 $realtime, out_data.screen_level, out_data.key_level);
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    checked++;
                    bad = (out_data.screen_level !== want.screen_level)
                       || (out_data.key_level !== want.key_level)
                       || (out_data.screen_blanked !== want.screen_blanked)
                       || (out_data.key_light_on !== want.key_light_on)
                       || (out_data.backlight_power_on !== want.backlight_power_on)
                       || (out_data.led_on !== want.led_on)
                       || (out_data.power_off_pulse !== want.power_off_pulse);
                    if (bad)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                        begin
                            $display("%0t: result %0d mismatch", $realtime, checked);
                            $display(
                                "  expected scr %0d key %0d blank %b keys %b bl %b led %b off %b",
                                want.screen_level, want.key_level, want.screen_blanked,
                                want.key_light_on, want.backlight_power_on,
                                want.led_on, want.power_off_pulse);
                            $display(
                                "  actual   scr %0d key %0d blank %b keys %b bl %b led %b off %b",
                                out_data.screen_level, out_data.key_level,
                                out_data.screen_blanked, out_data.key_light_on,
                                out_data.backlight_power_on, out_data.led_on,
                                out_data.power_off_pulse);
                        end
                    end
                end
            end

            if (in_valid && in_ready)
                predicted_outputs.push_back(predict_tick(in_data));

            // unknown indexes are dropped; a new timeout waits for the next arming
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BRIGHT_SCREEN: regs.bright_screen_level = cfg_data[LEVEL_BITS-1:0];
                    REG_BRIGHT_KEY:    regs.bright_key_level    = cfg_data[LEVEL_BITS-1:0];
                    REG_DIM_SCREEN:    regs.dim_screen_level    = cfg_data[LEVEL_BITS-1:0];
                    REG_DIM_KEY:       regs.dim_key_level       = cfg_data[LEVEL_BITS-1:0];
                    REG_SCREEN_IDLE:   regs.screen_idle_seconds = cfg_data[TIMER_BITS-1:0];
                    REG_KEY_IDLE:      regs.key_idle_seconds    = cfg_data[TIMER_BITS-1:0];
                    REG_POWER_DELAY:   regs.power_down_delay    = cfg_data[TIMER_BITS-1:0];
                    default:           ;
                endcase
            end

            pending = predicted_outputs.size();
        end
    end

endmodule

FILE: bench/tb_backlight_idle_power_controller.sv
// ----------------------------------------------------------------------------
// tb_backlight_idle_power_controller
// drives tick samples and register writes into the backlight and idle power
// controller under random stalls on both sides and gives the verdict; result
// checking is done by the tick checker that sits beside the block
// ----------------------------------------------------------------------------
module tb_backlight_idle_power_controller import bipc_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEG_COUNT    = 6;
    localparam int SEG_ITEMS    = 255;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 200000;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    bipc_in_if  in_ch ();
    bipc_out_if out_ch ();
    bipc_cfg_if cfg ();

    int   fail_count;
    int   pending;
    int   checked;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   ticks_sent;
    int   cfg_writes;
    int   cycles;
    logic hold_go;
    logic hold_done;
    logic lid_now;
    logic ac_now;

    always #5 clk = ~clk;

    backlight_idle_power_controller i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    bipc_tick_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_data    (in_ch.data),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_data   (out_ch.data),
        .cfg_valid  (cfg.valid),
        .cfg_ready  (cfg.ready),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    function automatic in_item_t sample_of(input logic lid, input logic ac, input logic key,
                                           input logic msg, input logic pd, input logic susp);
        in_item_t s;
        s.lid_up             = lid;
        s.on_ac              = ac;
        s.key_event          = key;
        s.msg_request        = msg;
        s.power_down_request = pd;
        s.suspend_request    = susp;
        return s;
    endfunction

    // mostly steady lid and supply with sparse events, some pure noise
    function automatic in_item_t random_tick();
        in_item_t s;
        if ($urandom_range(99) < 10)
        begin
            s = sample_of(1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        else
        begin
            if ($urandom_range(99) < 4)
                lid_now = ~lid_now;
            if ($urandom_range(99) < 5)
                ac_now = ~ac_now;
            s = sample_of(lid_now, ac_now, $urandom_range(99) < 12, $urandom_range(99) < 5,
                          $urandom_range(99) < 6, $urandom_range(99) < 3);
        end
        return s;
    endfunction

    // entered at a falling edge, returns at a falling edge with valid still high
    task automatic send_tick(input in_item_t s);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < tx_idle_pct)
                @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = s;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
        ticks_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = val;
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid = 1'b0;
        cfg_writes++;
    endtask

    task automatic load_regs(input logic [CFG_DATA_BITS-1:0] bright_scr,
                             input logic [CFG_DATA_BITS-1:0] bright_key,
                             input logic [CFG_DATA_BITS-1:0] dim_scr,
                             input logic [CFG_DATA_BITS-1:0] dim_key,
                             input logic [CFG_DATA_BITS-1:0] scr_idle,
                             input logic [CFG_DATA_BITS-1:0] key_idle,
                             input logic [CFG_DATA_BITS-1:0] pwr_delay);
        write_reg(REG_BRIGHT_SCREEN, bright_scr);
        write_reg(REG_BRIGHT_KEY, bright_key);
        write_reg(REG_DIM_SCREEN, dim_scr);
        write_reg(REG_DIM_KEY, dim_key);
        write_reg(REG_SCREEN_IDLE, scr_idle);
        write_reg(REG_KEY_IDLE, key_idle);
        write_reg(REG_POWER_DELAY, pwr_delay);
    endtask

    // stop offering and wait until every predicted result has been delivered
    task automatic drain();
        in_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        hold_done    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                out_ch.ready = 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(negedge clk);
                hold_done = 1'b1;
            end
            out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT_CYCLES)
            begin
                $display("tb_backlight_idle_power_controller failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        cfg.valid   = 1'b0;
        cfg.index   = '0;
        cfg.data    = '0;
        hold_go     = 1'b0;
        tx_idle_pct = 24;
        rx_idle_pct = 72;
        ticks_sent  = 0;
        cfg_writes  = 0;
        lid_now     = 1'b1;
        ac_now      = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // write to an unknown index must leave the defaults alone
        write_reg(REG_UNUSED, 16'hFFFF);

        // first tick leaves the unknown supply and lid, on battery
        send_tick(sample_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(sample_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(sample_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(sample_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(sample_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(sample_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(sample_of(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(sample_of(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        send_tick(sample_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(sample_of(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(sample_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        send_tick(sample_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(sample_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(sample_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(sample_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
        send_tick(sample_of(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(sample_of(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(sample_of(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
        send_tick(sample_of(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(sample_of(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(sample_of(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
        send_tick(sample_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
        drain();

        // zero keyboard level on battery: the flash can not be ended by a key
        write_reg(REG_DIM_KEY, 16'h0000);
        send_tick(sample_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(sample_of(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        send_tick(sample_of(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(sample_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(sample_of(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));

        for (int seg = 0; seg < SEG_COUNT; seg++)
        begin
            drain();
            tx_idle_pct = (seg < 2) ? 24 : ((seg < 4) ? 72 : 0);
            rx_idle_pct = (seg < 2) ? 72 : ((seg < 4) ? 24 : 0);
            case (seg)
                0: load_regs(16'($urandom_range(255)), 16'($urandom_range(255)),
                             16'($urandom_range(255)), 16'($urandom_range(255)),
                             16'($urandom_range(1, 12)), 16'($urandom_range(1, 6)),
                             16'($urandom_range(1, 5)));
                1: load_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                2: load_regs(16'd255, 16'd255, 16'd255, 16'd255, 16'hFFFF, 16'd1, 16'hFFFF);
                3: load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom_range(0, 10)), 16'($urandom_range(0, 10)),
                             16'($urandom_range(0, 10)));
                4: load_regs(16'($urandom_range(255)), 16'($urandom_range(255)),
                             16'($urandom_range(255)), 16'd0, 16'd1, 16'd1, 16'd1);
                default:
                begin
                    load_regs(16'($urandom_range(255)), 16'($urandom_range(255)),
                              16'($urandom_range(255)), 16'($urandom_range(255)),
                              16'($urandom_range(0, 20)), 16'($urandom_range(0, 9)),
                              16'($urandom_range(0, 6)));
                    write_reg(REG_UNUSED, 16'($urandom));
                end
            endcase
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                // long receiver hold-off while ticks keep coming
                if (seg == 1 && n == 40)
                    hold_go = 1'b1;
                if (seg == 3 && n == 120)
                    drain();
                send_tick(random_tick());
            end
        end

        drain();
        repeat (8) @(negedge clk);
        $display("run covered %0d tick samples and %0d register writes over %0d settings",
                 ticks_sent, cfg_writes, SEG_COUNT + 2);
        $display("%0d results checked, %0d mismatches, %0d still pending",
                 checked, fail_count, pending);
        if (fail_count == 0 && pending == 0)
            $display("tb_backlight_idle_power_controller passed");
        else
            $display("tb_backlight_idle_power_controller failed");
        $finish;
    end

endmodule

FILE: backlight_idle_power_controller.f
hw/rtl/bipc_pkg.sv
hw/rtl/bipc_in_if.sv
hw/rtl/bipc_out_if.sv
hw/rtl/bipc_cfg_if.sv
hw/rtl/bipc_step.sv
hw/rtl/backlight_idle_power_controller.sv
bench/bipc_tick_checker.sv
bench/tb_backlight_idle_power_controller.sv
